// ===== hdl/tgp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, command codes and the microcode table of the turtle grid plotter.
package tgp_pkg;

  localparam int STEPS_W = 6;
  localparam int FUNC_W = 3;
  localparam int ROWNUM_W = 5;
  localparam int OUT_W = 32;
  localparam int PC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    CMD_PEN_UP     = 3'd0,
    CMD_PEN_DOWN   = 3'd1,
    CMD_TURN_RIGHT = 3'd2,
    CMD_TURN_LEFT  = 3'd3,
    CMD_MOVE       = 3'd4,
    CMD_DUMP       = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    HD_RIGHT = 2'd0,
    HD_DOWN  = 2'd1,
    HD_LEFT  = 2'd2,
    HD_UP    = 2'd3
  } heading_e;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_SETUP,
    OP_LOOP,
    OP_POS,
    OP_DRD,
    OP_DOUT
  } dp_op_e;

  typedef enum logic [2:0] {
    JC_DISPATCH,
    JC_SKIP,
    JC_WHILE,
    JC_OUT,
    JC_GOTO
  } jump_e;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_FETCH    = 3'd0;
  localparam pc_t PC_MV_SETUP = 3'd1;
  localparam pc_t PC_MV_LOOP  = 3'd2;
  localparam pc_t PC_MV_POS   = 3'd3;
  localparam pc_t PC_DUMP_RD  = 3'd4;
  localparam pc_t PC_DUMP_OUT = 3'd5;

  typedef struct packed {
    logic     accept;
    dp_op_e   op;
    jump_e    jump;
    pc_t      target;
  } cw_t;

  typedef struct packed {
    logic skip;
    logic loop_go;
    logic out_load;
    logic last_row;
  } dp_status_t;

  function automatic cw_t ucode_rom(input pc_t pc);
    cw_t cw;
    cw = '{accept: 1'b0, op: OP_FETCH, jump: JC_GOTO, target: PC_FETCH};
    case (pc)
      PC_FETCH:    cw = '{accept: 1'b1, op: OP_FETCH, jump: JC_DISPATCH, target: PC_FETCH};
      PC_MV_SETUP: cw = '{accept: 1'b0, op: OP_SETUP, jump: JC_SKIP, target: PC_MV_POS};
      PC_MV_LOOP:  cw = '{accept: 1'b0, op: OP_LOOP, jump: JC_WHILE, target: PC_MV_POS};
      PC_MV_POS:   cw = '{accept: 1'b0, op: OP_POS, jump: JC_GOTO, target: PC_FETCH};
      PC_DUMP_RD:  cw = '{accept: 1'b0, op: OP_DRD, jump: JC_GOTO, target: PC_DUMP_OUT};
      PC_DUMP_OUT: cw = '{accept: 1'b0, op: OP_DOUT, jump: JC_OUT, target: PC_DUMP_RD};
      default: begin
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/tgp_grid.sv =====
`timescale 1ns / 1ps
// Bitmap row memory with per-row valid bits so that reset clears every cell.
module tgp_grid #(
  parameter int GRID_SIZE = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           re_i,
  input  logic [$clog2(GRID_SIZE)-1:0]   raddr_i,
  input  logic                           we_i,
  input  logic [$clog2(GRID_SIZE)-1:0]   waddr_i,
  input  logic [((GRID_SIZE < 32) ? GRID_SIZE : 32)-1:0] wdata_i,
  output logic [((GRID_SIZE < 32) ? GRID_SIZE : 32)-1:0] rdata_o
);

  localparam int ROW_W = (GRID_SIZE < 32) ? GRID_SIZE : 32;

  logic [ROW_W-1:0]     mem_q [GRID_SIZE];
  logic [ROW_W-1:0]     rd_q;
  logic [GRID_SIZE-1:0] valid_q;
  logic                 rv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rv_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rv_q ? rd_q : '0;

endmodule

// ===== hdl/tgp_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store and jump logic.
module tgp_seq
  import tgp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  dp_status_t          status_i,
  output cw_t                 cw_o
);

  pc_t pc_q;
  pc_t pc_d;
  pc_t pc_inc;

  assign cw_o   = ucode_rom(pc_q);
  assign pc_inc = pc_q + PC_W'(1);

  always_comb begin
    pc_d = pc_q;
    unique case (cw_o.jump)
      JC_DISPATCH: begin
        if (take_i && func_i == CMD_MOVE) begin
          pc_d = PC_MV_SETUP;
        end else if (take_i && func_i == CMD_DUMP) begin
          pc_d = PC_DUMP_RD;
        end
      end
      JC_SKIP:  pc_d = status_i.skip ? cw_o.target : pc_inc;
      JC_WHILE: pc_d = status_i.loop_go ? pc_q : pc_inc;
      JC_OUT: begin
        if (status_i.out_load) begin
          pc_d = status_i.last_row ? PC_FETCH : cw_o.target;
        end
      end
      JC_GOTO:  pc_d = cw_o.target;
      default:  pc_d = PC_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hdl/tgp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: turtle state, move address and mask generation, and the output register.
module tgp_dp
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cw_t                            cw_i,
  input  logic                           take_i,
  input  logic [FUNC_W-1:0]              func_i,
  input  logic [STEPS_W-1:0]             steps_i,
  output dp_status_t                     status_o,
  output logic                           re_o,
  output logic [$clog2(GRID_SIZE)-1:0]   raddr_o,
  output logic                           we_o,
  output logic [$clog2(GRID_SIZE)-1:0]   waddr_o,
  output logic [((GRID_SIZE < 32) ? GRID_SIZE : 32)-1:0] wdata_o,
  input  logic [((GRID_SIZE < 32) ? GRID_SIZE : 32)-1:0] rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [OUT_W-1:0]               row_bits_o,
  output logic [ROWNUM_W-1:0]            row_number_o,
  output logic                           last_o
);

  localparam int POS_W = $clog2(GRID_SIZE);
  localparam int ROW_W = (GRID_SIZE < 32) ? GRID_SIZE : 32;
  localparam int KW = (POS_W > STEPS_W) ? POS_W : STEPS_W;
  localparam int SW = KW + 2;

  logic                pen_q, pen_d;
  heading_e            heading_q, heading_d;
  logic [POS_W-1:0]    pos_row_q, pos_row_d;
  logic [POS_W-1:0]    pos_col_q, pos_col_d;
  logic [STEPS_W-1:0]  steps_q;
  logic [KW-1:0]       k_q, k_d;
  logic [KW-1:0]       limit_q;
  logic [ROW_W-1:0]    mask_q;
  logic                wr_pend_q, wr_pend_d;
  logic [POS_W-1:0]    wr_row_q;
  logic                out_valid_q, out_valid_d;
  logic [ROW_W-1:0]    out_bits_q;
  logic [ROWNUM_W-1:0] out_num_q;
  logic                out_last_q;

  logic signed [SW-1:0] pr_s, pc_s, k_s, steps_s, row_s, lo_s, hi_s;
  logic                 vert;
  logic                 in_grid;
  logic                 loop_go;
  logic                 out_load;
  logic                 last_row;
  logic                 dout_fire;
  logic [ROW_W-1:0]     hmask, vmask;

  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SW-1:0] v);
    logic [POS_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(SW'(GRID_SIZE - 1))) begin
      r = POS_W'(GRID_SIZE - 1);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  assign pr_s    = $signed(SW'(pos_row_q));
  assign pc_s    = $signed(SW'(pos_col_q));
  assign k_s     = $signed(SW'(k_q));
  assign steps_s = $signed(SW'(steps_q));
  assign vert    = (heading_q == HD_DOWN) || (heading_q == HD_UP);

  always_comb begin
    unique case (heading_q)
      HD_DOWN: row_s = pr_s + k_s;
      HD_UP:   row_s = pr_s - k_s;
      default: row_s = pr_s;
    endcase
  end

  assign in_grid  = (row_s >= 0) && (row_s < $signed(SW'(GRID_SIZE)));
  assign loop_go  = (k_q < limit_q) && in_grid;
  assign out_load = !out_valid_q || !out_stall_i;
  assign last_row = (k_q == KW'(GRID_SIZE - 1));

  always_comb begin
    if (heading_q == HD_LEFT) begin
      lo_s = pc_s - steps_s + SW'(1);
      hi_s = pc_s;
    end else begin
      lo_s = pc_s;
      hi_s = pc_s + steps_s - SW'(1);
    end
    for (int c = 0; c < ROW_W; c++) begin
      hmask[c] = ($signed(SW'(c)) >= lo_s) && ($signed(SW'(c)) <= hi_s);
      vmask[c] = (pos_col_q == POS_W'(c));
    end
  end

  assign status_o.skip     = !pen_q || (steps_q == '0);
  assign status_o.loop_go  = loop_go;
  assign status_o.out_load = out_load;
  assign status_o.last_row = last_row;

  assign dout_fire = (cw_i.op == OP_DOUT) && out_load;

  always_comb begin
    pen_d       = pen_q;
    heading_d   = heading_q;
    pos_row_d   = pos_row_q;
    pos_col_d   = pos_col_q;
    k_d         = k_q;
    wr_pend_d   = 1'b0;
    re_o        = 1'b0;
    raddr_o     = row_s[POS_W-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    unique case (cw_i.op)
      OP_FETCH: begin
        if (take_i) begin
          k_d = '0;
          case (func_i)
            CMD_PEN_UP:     pen_d = 1'b0;
            CMD_PEN_DOWN:   pen_d = 1'b1;
            CMD_TURN_RIGHT: heading_d = heading_e'(heading_q + 2'd1);
            CMD_TURN_LEFT:  heading_d = heading_e'(heading_q + 2'd3);
            default: begin
            end
          endcase
        end
      end
      OP_SETUP: begin
        k_d = '0;
      end
      OP_LOOP: begin
        if (loop_go) begin
          re_o      = 1'b1;
          wr_pend_d = 1'b1;
          k_d       = k_q + KW'(1);
        end
      end
      OP_POS: begin
        unique case (heading_q)
          HD_RIGHT: pos_col_d = clamp_pos(pc_s + steps_s);
          HD_LEFT:  pos_col_d = clamp_pos(pc_s - steps_s);
          HD_DOWN:  pos_row_d = clamp_pos(pr_s + steps_s);
          HD_UP:    pos_row_d = clamp_pos(pr_s - steps_s);
          default: begin
          end
        endcase
      end
      OP_DRD: begin
        re_o    = 1'b1;
        raddr_o = k_q[POS_W-1:0];
      end
      OP_DOUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          k_d         = k_q + KW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q       <= 1'b0;
      heading_q   <= HD_RIGHT;
      pos_row_q   <= '0;
      pos_col_q   <= '0;
      k_q         <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pen_q       <= pen_d;
      heading_q   <= heading_d;
      pos_row_q   <= pos_row_d;
      pos_col_q   <= pos_col_d;
      k_q         <= k_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.op == OP_FETCH && take_i) begin
      steps_q <= steps_i;
    end
    if (cw_i.op == OP_SETUP) begin
      mask_q  <= vert ? vmask : hmask;
      limit_q <= vert ? KW'(steps_q) : KW'(1);
    end
    if (cw_i.op == OP_LOOP) begin
      wr_row_q <= row_s[POS_W-1:0];
    end
    if (dout_fire) begin
      out_bits_q <= rdata_i;
      out_num_q  <= k_q[ROWNUM_W-1:0];
      out_last_q <= last_row;
    end
  end

  assign we_o         = wr_pend_q;
  assign waddr_o      = wr_row_q;
  assign wdata_o      = rdata_i | mask_q;
  assign out_valid_o  = out_valid_q;
  assign row_bits_o   = OUT_W'(out_bits_q);
  assign row_number_o = out_num_q;
  assign last_o       = out_last_q;

endmodule

// ===== hdl/turtle_grid_plotter_core.sv =====
`timescale 1ns / 1ps
// Turtle grid plotter top level.
//
// Commands arrive on the input channel (in_valid_i, in_stall_o, func_i, steps_i) and are
// taken at a clock edge where in_valid_i is high and in_stall_o is low. Only the dump
// command produces results; each result is one grid row on the output channel
// (out_valid_o, out_stall_i, row_bits_o, row_number_o, last_o), top row first, last_o set
// on the final row. A single output register holds a row until it is taken.
// Pen and turn commands finish in the fetch step, so they can arrive back to back. A move
// runs a setup step, a row loop and a position step; the row loop reads and writes the
// row memory one row per cycle, one row for a horizontal move and at most steps rows for
// a vertical one. A move with the pen up or zero steps skips the row loop. A dump reads
// each row from the row memory and then loads it into the output register.
// When the receiver stalls, the sequencer waits at the output step and in_stall_o stays
// high until the dump has loaded its last row.
// Reset clears the turtle to pen up, facing right, at row 0 and column 0. Per-row valid
// bits make the whole bitmap read as clear right after reset, with no clearing pass.
module turtle_grid_plotter_core
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [STEPS_W-1:0]  steps_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_W-1:0]    row_bits_o,
  output logic [ROWNUM_W-1:0] row_number_o,
  output logic                last_o
);

  localparam int POS_W = $clog2(GRID_SIZE);
  localparam int ROW_W = (GRID_SIZE < 32) ? GRID_SIZE : 32;

  cw_t              cw;
  dp_status_t       status;
  logic             take;
  logic             re, we;
  logic [POS_W-1:0] raddr, waddr;
  logic [ROW_W-1:0] wdata, rdata;

  assign in_stall_o = !cw.accept;
  assign take       = in_valid_i && cw.accept;

  tgp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .func_i   (func_i),
    .status_i (status),
    .cw_o     (cw)
  );

  tgp_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cw_i         (cw),
    .take_i       (take),
    .func_i       (func_i),
    .steps_i      (steps_i),
    .status_o     (status),
    .re_o         (re),
    .raddr_o      (raddr),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .rdata_i      (rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_bits_o   (row_bits_o),
    .row_number_o (row_number_o),
    .last_o       (last_o)
  );

  tgp_grid #(
    .GRID_SIZE (GRID_SIZE)
  ) u_grid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (re),
    .raddr_i (raddr),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

endmodule

// ===== hdl/tgp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the turtle grid plotter, bound to the top level.
module tgp_checker
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [FUNC_W-1:0]   func_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [OUT_W-1:0]    row_bits_o,
  input logic [ROWNUM_W-1:0] row_number_o,
  input logic                last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_bits_o) &&
      $stable(row_number_o) && $stable(last_o))
    else $error("Stalled output row changed or was dropped.");

  a_busy_mid_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("Request taken while a dump is still in progress.");

  a_last_row_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> row_number_o == ROWNUM_W'(GRID_SIZE - 1))
    else $error("Last row of a dump carries the wrong row number.");

  a_long_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == CMD_MOVE || func_i == CMD_DUMP) |=> in_stall_o)
    else $error("Move or dump request did not occupy the block.");

endmodule

bind turtle_grid_plotter_core tgp_checker #(
  .GRID_SIZE (GRID_SIZE)
) u_tgp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .func_i       (func_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .row_bits_o   (row_bits_o),
  .row_number_o (row_number_o),
  .last_o       (last_o)
);
